// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker, dll_checker.sv.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dll_pkg.sv
// Types and codes for the linked list engine.
// No dependencies.
package dll_pkg;

  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_BACK  = 3'd1;
  localparam logic [2:0] FN_INS_AT    = 3'd2;
  localparam logic [2:0] FN_DEL_FRONT = 3'd3;
  localparam logic [2:0] FN_DEL_BACK  = 3'd4;
  localparam logic [2:0] FN_DEL_AT    = 3'd5;
  localparam logic [2:0] FN_DUMP_FWD  = 3'd6;
  localparam logic [2:0] FN_DUMP_REV  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_LINK1,
    S_LINK2,
    S_UNLINK,
    S_DUMP,
    S_RESP
  } state_t;

endpackage

// File: rtl/doubly_linked_list_engine.sv
// Linked list engine: node pool in three memories with registered reads. Depends on dll_pkg.
// After decide, front/back inserts and errors go straight to the response, front/back
// deletes unlink first, insert at walks then links (LINK1, LINK2), delete at walks then unlinks.
// Walks follow one link per cycle; dumps give one result per cycle while not stalled.
// One item at a time: the next is taken the cycle after the last result is loaded.
// Synchronous active-low reset empties the list and frees the pool; memories keep contents.
module doubly_linked_list_engine import dll_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value_res,
  output logic               out_last,
  output logic [4:0]         out_length
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  state_t state_r, state_nxt;

  logic [2:0]          func_r;
  logic signed [31:0]  val_r;
  logic [4:0]          pos_r;

  logic [IW-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [CAPACITY-1:0] free_r, free_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       cur_r, cur_nxt, node_r, node_nxt;
  logic [XW-1:0]       k_r, k_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic signed [31:0]  res_value_r, res_value_nxt;

  logic                out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic signed [31:0]  out_value_r, out_value_nxt;
  logic [4:0]          out_length_r, out_length_nxt;

  logic signed [31:0]  vmem [CAPACITY];
  logic [IW-1:0]       nmem [CAPACITY];
  logic [IW-1:0]       pmem [CAPACITY];
  logic signed [31:0]  vrd;
  logic [IW-1:0]       nrd, prd, rd_addr;
  logic                v_we, n_we, p_we;
  logic [IW-1:0]       v_wa, n_wa, p_wa, n_wd, p_wd;

  logic [IW-1:0]       free_lo;
  logic [XW-1:0]       pos_x, cnt_x;
  logic                is_ins, is_del, empty, full, ins_front, ins_back;
  logic                dec_fail, walk_hit, dump_last, out_free;
  logic [1:0]          dec_status;

  assign pos_x     = XW'(pos_r);
  assign cnt_x     = XW'(count_r);
  assign is_ins    = func_r inside {FN_INS_FRONT, FN_INS_BACK, FN_INS_AT};
  assign is_del    = func_r inside {FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT};
  assign empty     = (count_r == '0);
  assign full      = (count_r >= CW'(CAPACITY));
  assign ins_front = (func_r == FN_INS_FRONT) || (func_r == FN_INS_AT && pos_r == '0);
  assign ins_back  = (func_r == FN_INS_BACK) || (func_r == FN_INS_AT && pos_x == cnt_x);
  assign walk_hit  = (k_r == pos_x);
  assign dump_last = (k_r + XW'(1) == cnt_x);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    dec_fail   = 1'b0;
    dec_status = ST_OK;
    if (is_ins) begin
      if (func_r == FN_INS_AT && pos_x > cnt_x) begin
        dec_fail   = 1'b1;
        dec_status = ST_RANGE;
      end else if (full) begin
        dec_fail   = 1'b1;
        dec_status = ST_FULL;
      end
    end else if (empty) begin
      dec_fail   = 1'b1;
      dec_status = ST_EMPTY;
    end else if (func_r == FN_DEL_AT && pos_x >= cnt_x) begin
      dec_fail   = 1'b1;
      dec_status = ST_RANGE;
    end
  end

  // lowest free node
  always_comb begin
    free_lo = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_r[i]) free_lo = IW'(i);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (dec_fail) state_nxt = S_RESP;
        else if (is_ins) state_nxt = (ins_front || ins_back) ? S_RESP : S_WALK;
        else if (is_del) state_nxt = (func_r == FN_DEL_AT) ? S_WALK : S_UNLINK;
        else state_nxt = S_DUMP;
      end
      S_WALK:   if (walk_hit) state_nxt = is_ins ? S_LINK1 : S_UNLINK;
      S_LINK1:  state_nxt = S_LINK2;
      S_LINK2:  state_nxt = S_RESP;
      S_UNLINK: state_nxt = S_RESP;
      S_DUMP:   if (out_free && dump_last) state_nxt = S_IDLE;
      S_RESP:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    node_nxt       = node_r;
    k_nxt          = k_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_length_nxt = out_length_r;
    rd_addr        = cur_r;
    v_we = 1'b0; v_wa = '0; n_we = 1'b0; n_wa = '0; n_wd = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0;
    case (state_r)
      S_DECIDE: begin
        res_status_nxt = dec_status;
        res_value_nxt  = '0;
        k_nxt          = '0;
        if (dec_fail) begin
          res_value_nxt = '0;
        end else if (is_ins) begin
          res_value_nxt    = val_r;
          node_nxt         = free_lo;
          free_nxt[free_lo] = 1'b0;
          count_nxt        = count_r + CW'(1);
          v_we = 1'b1; v_wa = free_lo;
          if (ins_front) begin
            if (empty) tail_nxt = free_lo;
            else begin
              n_we = 1'b1; n_wa = free_lo; n_wd = head_r;
              p_we = 1'b1; p_wa = head_r;  p_wd = free_lo;
            end
            head_nxt = free_lo;
          end else if (ins_back) begin
            if (empty) head_nxt = free_lo;
            else begin
              p_we = 1'b1; p_wa = free_lo; p_wd = tail_r;
              n_we = 1'b1; n_wa = tail_r;  n_wd = free_lo;
            end
            tail_nxt = free_lo;
          end else begin
            cur_nxt = head_r;
            rd_addr = head_r;
          end
        end else if (func_r == FN_DEL_BACK || func_r == FN_DUMP_REV) begin
          cur_nxt = tail_r;
          rd_addr = tail_r;
        end else begin
          cur_nxt = head_r;
          rd_addr = head_r;
        end
      end
      S_WALK: begin
        if (!walk_hit) begin
          cur_nxt = nrd;
          rd_addr = nrd;
          k_nxt   = k_r + XW'(1);
        end
      end
      S_LINK1: begin
        n_we = 1'b1; n_wa = prd;    n_wd = node_r;
        p_we = 1'b1; p_wa = node_r; p_wd = prd;
      end
      S_LINK2: begin
        n_we = 1'b1; n_wa = node_r; n_wd = cur_r;
        p_we = 1'b1; p_wa = cur_r;  p_wd = node_r;
      end
      S_UNLINK: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = vrd;
        if (count_r <= CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (cur_r == head_r) begin
          head_nxt = nrd;
        end else if (cur_r == tail_r) begin
          tail_nxt = prd;
        end else begin
          n_we = 1'b1; n_wa = prd; n_wd = nrd;
          p_we = 1'b1; p_wa = nrd; p_wd = prd;
        end
        free_nxt[cur_r] = 1'b1;
        count_nxt       = count_r - CW'(1);
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = vrd;
          out_last_nxt   = dump_last;
          out_length_nxt = 5'(count_r);
          if (!dump_last) begin
            cur_nxt = (func_r == FN_DUMP_FWD) ? nrd : prd;
            rd_addr = cur_nxt;
            k_nxt   = k_r + XW'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_last_nxt   = 1'b1;
          out_length_nxt = 5'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_wa] <= val_r;
    if (n_we) nmem[n_wa] <= n_wd;
    if (p_we) pmem[p_wa] <= p_wd;
    vrd <= vmem[rd_addr];
    nrd <= nmem[rd_addr];
    prd <= pmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= {CAPACITY{1'b1}};
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_func;
      val_r  <= in_value;
      pos_r  <= in_position;
    end
    cur_r        <= cur_nxt;
    node_r       <= node_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_length_r <= out_length_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_res = out_value_r;
  assign out_last      = out_last_r;
  assign out_length    = out_length_r;

endmodule

// File: rtl/dll_checker.sv
// Port-level checks for the linked list engine, bound to the engine module.
// Depends on dll_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dll_checker import dll_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_value_res,
  input logic               out_last,
  input logic [4:0]         out_length
);

  `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_value_res), "stalled item lost")
  `ASSERT_NOW(a_mid_ok, out_valid && !out_last, out_status == ST_OK, "error item not last")
  `ASSERT_NOW(a_err_zero, out_valid && out_status != ST_OK, out_value_res == 0, "error value not zero")
  `ASSERT_NOW(a_empty_len, out_valid && out_status == ST_EMPTY, out_length == 0, "empty with length")

endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (.*);

// File: tb/sv/doubly_linked_list_engine_checker.sv
// Checker for the linked list engine: watches both channels, keeps its own list
// and compares every result item with the oldest expected one. Depends on dll_pkg.
module doubly_linked_list_engine_checker import dll_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic signed [31:0] out_value_res,
  input  logic               out_last,
  input  logic [4:0]         out_length,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic        last;
    logic [4:0]  length;
  } list_result_t;

  localparam int DEPTH = 16;

  // Queue model of the list: same values, order and count as the pool.
  logic [31:0]  elems[$];
  list_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic list_result_t mk(logic [1:0] st, logic [31:0] v, logic l);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.last   = l;
    r.length = 5'(elems.size());
    return r;
  endfunction

  task automatic predict_request(logic [2:0] fn, logic [31:0] v, logic [4:0] pos);
    int n;
    logic [31:0] d;
    n = elems.size();
    case (fn)
      FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
        if (fn == FN_INS_AT && pos > n) expected_q.push_back(mk(ST_RANGE, 0, 1'b1));
        else if (n >= DEPTH) expected_q.push_back(mk(ST_FULL, 0, 1'b1));
        else begin
          if (fn == FN_INS_FRONT) elems.push_front(v);
          else if (fn == FN_INS_BACK) elems.push_back(v);
          else elems.insert(pos, v);
          expected_q.push_back(mk(ST_OK, v, 1'b1));
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT: begin
        if (n == 0) expected_q.push_back(mk(ST_EMPTY, 0, 1'b1));
        else if (fn == FN_DEL_AT && pos >= n) expected_q.push_back(mk(ST_RANGE, 0, 1'b1));
        else begin
          if (fn == FN_DEL_FRONT) d = elems.pop_front();
          else if (fn == FN_DEL_BACK) d = elems.pop_back();
          else begin
            d = elems[pos];
            elems.delete(pos);
          end
          expected_q.push_back(mk(ST_OK, d, 1'b1));
        end
      end
      default: begin
        if (n == 0) expected_q.push_back(mk(ST_EMPTY, 0, 1'b1));
        else
          for (int k = 0; k < n; k++)
            expected_q.push_back(mk(ST_OK, (fn == FN_DUMP_FWD) ? elems[k] : elems[n-1-k],
                                    k == n - 1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    list_result_t got, exp_r;
    if (!rst_n) begin
      elems.delete();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) predict_request(in_func, in_value, in_position);
      if (out_valid && !out_stall) begin
        got = {out_status, out_value_res, out_last, out_length};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected st=%0d val=%h last=%0d len=%0d, actual st=%0d val=%h last=%0d len=%0d",
                     $time, exp_r.status, exp_r.value, exp_r.last, exp_r.length,
                     got.status, got.value, got.last, got.length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/doubly_linked_list_engine_tb.sv
// Testbench top for the linked list engine: clock, reset, request stimulus
// and verdict. Depends on dll_pkg, doubly_linked_list_engine and doubly_linked_list_engine_checker.
module doubly_linked_list_engine_tb;
  import dll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [2:0] in_func = '0;
  logic signed [31:0] in_value = '0;
  logic [4:0] in_position = '0;
  logic in_stall, out_valid, out_last;
  logic [1:0] out_status;
  logic signed [31:0] out_value_res;
  logic [4:0] out_length;
  int fail_count, pending;
  int cycles = 0;
  bit quiet = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  doubly_linked_list_engine u_top (.*);

  doubly_linked_list_engine_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("doubly_linked_list_engine regression: fail");
      $finish;
    end
  end

  // Stall the result side about 22% of cycles, except in the quiet stretch.
  always @(posedge clk) out_stall <= !quiet && rst_n && ($urandom_range(99) < 22);

  task automatic send(logic [2:0] fn, logic [31:0] v, logic [4:0] pos);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_value    <= v;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int n;
    logic [2:0] fn;
    logic [31:0] v;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Empty list: every delete and dump, out-of-range insert; then edge-value inserts, out-of-range deletes, dumps.
    send(FN_DEL_FRONT, 0, 0);
    send(FN_DEL_BACK, 0, 0);
    send(FN_DEL_AT, 0, 0);
    send(FN_DUMP_FWD, 0, 0);
    send(FN_DUMP_REV, 0, 0);
    send(FN_INS_AT, 32'h1, 1);
    send(FN_INS_AT, 32'h7fffffff, 0);
    send(FN_INS_FRONT, 32'h80000000, 0);
    send(FN_INS_BACK, 32'hffffffff, 0);
    send(FN_INS_AT, 32'h0, 3);
    send(FN_INS_AT, 32'h12345678, 1);
    send(FN_DEL_AT, 0, 5);
    send(FN_DEL_AT, 0, 31);
    send(FN_DUMP_FWD, 0, 0);
    send(FN_DUMP_REV, 0, 0);
    // Fill the pool, then hit full.
    for (int i = 0; i < 12; i++) send(FN_INS_BACK, $urandom, 0);
    send(FN_INS_FRONT, 32'h5a5a5a5a, 0);
    send(FN_INS_AT, 32'h5, 16);
    send(FN_DUMP_REV, 0, 0);
    send(FN_DEL_AT, 0, 15);
    send(FN_DEL_AT, 0, 7);
    send(FN_DEL_FRONT, 0, 0);
    send(FN_DEL_BACK, 0, 0);
    n = 12;
    for (int i = 0; i < 500; i++) begin
      quiet = (i >= 200 && i < 260);
      fn = 3'($urandom_range(7));
      // Bias towards inserts when short, deletes when long.
      if (fn <= FN_INS_AT && n > 12 && $urandom_range(1)) fn = 3'($urandom_range(3, 5));
      if (fn >= FN_DEL_FRONT && fn <= FN_DEL_AT && n < 3 && $urandom_range(1))
        fn = 3'($urandom_range(2));
      v = $urandom;
      send(fn, v, ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(n)));
      n = u_chk.elems.size();
    end
    quiet = 0;
    in_valid <= 1'b0;
    // let the checker take in the last item before draining
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("doubly_linked_list_engine regression: pass");
    else $display("doubly_linked_list_engine regression: fail");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/dll_pkg.sv
rtl/doubly_linked_list_engine.sv
rtl/dll_checker.sv
tb/sv/doubly_linked_list_engine_checker.sv
tb/sv/doubly_linked_list_engine_tb.sv
